// ----- sv/sonrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sonrc_pkg;

    // Sensor array and field widths
    localparam int SENSOR_COUNT = 16;
    localparam int SENSOR_W     = $clog2(SENSOR_COUNT);
    localparam int INDEX_W      = 4;
    localparam int IDX_EXT_W    = INDEX_W + 1;
    localparam int RANGE_W      = 13;
    localparam int MASK_W       = 16;
    localparam int ANGLE_W      = 13;

    // Only the two newest raw samples are ever read back; the oldest leaves the window
    localparam int HIST_W       = 2 * RANGE_W;

    // Filter arithmetic: sum of three samples and divide by three via reciprocal
    localparam int SUM_W        = RANGE_W + 2;
    localparam int RECIP_W      = 16;
    localparam int MEAN_PROD_W  = SUM_W + RECIP_W;
    localparam int MEAN_SHIFT   = 17;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 16'hAAAB;

    localparam logic [RANGE_W-1:0] CAP_MM = 13'd5000;

    // Shared shift-subtract divider
    localparam int DIVIDEND_W   = 40;
    localparam int DIVISOR_W    = 30;
    localparam int STEP_W       = 6;
    localparam int WEIGHT_W     = 25;
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = 6'd25;
    localparam logic [STEP_W-1:0] ANGLE_STEPS  = 6'd40;
    // 2^24 left-aligned in the dividend register for a 25-step division
    localparam logic [DIVIDEND_W-1:0] WEIGHT_DIVIDEND = {1'b1, {(DIVIDEND_W-1){1'b0}}};

    // Bearing and accumulators
    localparam int BEARING_W    = 14;
    localparam int PROD_W       = BEARING_W + WEIGHT_W + 1;
    localparam int AWS_W        = 40;
    localparam int WS_W         = 30;
    localparam logic [BEARING_W-1:0] BEARING_STEP   = 14'd360;
    localparam logic [BEARING_W-1:0] BEARING_OFFSET = 14'd2880;
    localparam logic signed [AWS_W:0] AWS_POS_SAT = 41'sd549755813887;
    localparam logic signed [AWS_W:0] AWS_NEG_SAT = -41'sd549755813887;
    localparam logic [WS_W-1:0] WS_SAT = {WS_W{1'b1}};

    // Bearing limits in sixteenths of a degree
    localparam logic [DIVIDEND_W-1:0] ANGLE_NEG_MAG  = 40'd2880;
    localparam logic [DIVIDEND_W-1:0] ANGLE_POS_MAG  = 40'd2520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LOW  = -13'sd2880;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HIGH = 13'sd2520;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAFE_DIST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRIT_DIST  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTLIER    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_MASK = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_MASK  = 3'd4;

    localparam logic [RANGE_W-1:0] SAFE_DIST_RST  = 13'd800;
    localparam logic [RANGE_W-1:0] CRIT_DIST_RST  = 13'd400;
    localparam logic [RANGE_W-1:0] OUTLIER_RST    = 13'd1000;
    localparam logic [MASK_W-1:0]  FRONT_MASK_RST = 16'hF00F;
    localparam logic [MASK_W-1:0]  SIDE_MASK_RST  = 16'h0FF0;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FILT,
        ST_MEAN,
        ST_ACC,
        ST_WDIV,
        ST_MUL,
        ST_SUM,
        ST_SCAN,
        ST_ADIV,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic mem_read;
        logic filt;
        logic mean;
        logic acc;
        logic wdiv_start;
        logic mul;
        logic sum;
        logic adiv_start;
        logic angle_take;
        logic angle_zero;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic near;
        logic last;
        logic obstacle;
        logic ws_nonzero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/sonrc_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sonrc_divider
    import sonrc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    input  wire logic [STEP_W-1:0]     steps,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]     count_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // Trial subtract of one dividend bit per cycle
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = ~diff[DIVISOR_W+1];
        rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    // Control: load on start, count down steps, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && count_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            quo_reg   <= dividend;
            dvs_reg   <= divisor;
            count_reg <= steps;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            quo_reg   <= {quo_reg[DIVIDEND_W-2:0], fits};
            count_reg <= count_reg - STEP_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/sonrc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sonrc_ctrl
    import sonrc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one item through read, filter, accumulate, summary and emit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_FILT;
            end
            ST_FILT: begin
                cmd.filt   = 1'b1;
                state_next = ST_MEAN;
            end
            ST_MEAN: begin
                cmd.mean   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (stat.near) begin
                    cmd.wdiv_start = 1'b1;
                    state_next     = ST_WDIV;
                end else if (stat.last) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_WDIV: begin
                if (stat.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = stat.last ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN: begin
                if (stat.obstacle && stat.ws_nonzero) begin
                    cmd.adiv_start = 1'b1;
                    state_next     = ST_ADIV;
                end else begin
                    cmd.angle_zero = stat.obstacle;
                    state_next     = ST_EMIT;
                end
            end
            ST_ADIV: begin
                if (stat.div_done) begin
                    cmd.angle_take = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/sonrc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sonrc_datapath
    import sonrc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    input  wire logic [INDEX_W-1:0]    sensor_index,
    input  wire logic [RANGE_W-1:0]    range_mm,
    input  wire logic                  reading_present,
    input  wire logic                  end_of_scan,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast
);

    // Configuration registers
    logic [RANGE_W-1:0] safe_reg, crit_reg, thr_reg;
    logic [MASK_W-1:0]  front_mask_reg, side_mask_reg;

    // Captured input beat
    logic [INDEX_W-1:0] idx_reg;
    logic [RANGE_W-1:0] range_reg;
    logic               present_reg;
    logic               last_reg;
    logic               in_range;
    logic [SENSOR_W-1:0] addr;

    // History memory
    logic [HIST_W-1:0]       hist_mem_reg [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] row_valid_reg;
    logic [HIST_W-1:0]       rd_row_reg;
    logic                    rd_valid_reg;
    logic [RANGE_W-1:0]      h0, h1, raw;
    logic                    wr_en;

    // Filter
    logic [SUM_W-1:0]       sum, three_raw, gap, thr3;
    logic [SUM_W-1:0]       sum_reg;
    logic                   outlier_reg;
    logic [RANGE_W-1:0]     prev_reg;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [RANGE_W-1:0]     mean;
    logic [RANGE_W-1:0]     f_reg;
    logic [RANGE_W-1:0]     capped;

    // Scan accumulators
    logic [RANGE_W-1:0]          fmin_reg, smin_reg;
    logic signed [AWS_W-1:0]     aws_reg;
    logic [WS_W-1:0]             ws_reg;
    logic signed [ANGLE_W-1:0]   held_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [BEARING_W-1:0] bearing;
    logic signed [AWS_W:0]       aws_sum;
    logic [WS_W:0]               ws_sum;
    logic [DIVIDEND_W-1:0]       aws_mag;
    logic signed [ANGLE_W-1:0]   angle;

    // Divider interface
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;
    logic                 obstacle, unsafe;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_reg       <= SAFE_DIST_RST;
            crit_reg       <= CRIT_DIST_RST;
            thr_reg        <= OUTLIER_RST;
            front_mask_reg <= FRONT_MASK_RST;
            side_mask_reg  <= SIDE_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SAFE_DIST:  safe_reg       <= cfg_wdata[RANGE_W-1:0];
                CFG_CRIT_DIST:  crit_reg       <= cfg_wdata[RANGE_W-1:0];
                CFG_OUTLIER:    thr_reg        <= cfg_wdata[RANGE_W-1:0];
                CFG_FRONT_MASK: front_mask_reg <= cfg_wdata[MASK_W-1:0];
                CFG_SIDE_MASK:  side_mask_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            idx_reg     <= sensor_index;
            range_reg   <= range_mm;
            present_reg <= reading_present;
            last_reg    <= end_of_scan;
        end
    end

    assign in_range = IDX_EXT_W'(idx_reg) < IDX_EXT_W'(SENSOR_COUNT);
    assign addr     = idx_reg[SENSOR_W-1:0];

    // Unwritten rows read as the capped reset range
    assign h0  = rd_valid_reg ? rd_row_reg[RANGE_W-1:0]       : CAP_MM;
    assign h1  = rd_valid_reg ? rd_row_reg[HIST_W-1:RANGE_W]  : CAP_MM;
    assign raw = present_reg ? range_reg : h0;
    assign wr_en = cmd.filt && in_range;

    // History memory: registered read, shift newest sample in on write
    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_row_reg <= hist_mem_reg[addr];
        end
        if (wr_en) begin
            hist_mem_reg[addr] <= {h0, raw};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_valid_reg <= row_valid_reg[addr];
        end
    end

    // Outlier test in thirds: |3*raw - sum| against 3*threshold
    always_comb begin
        sum       = SUM_W'(raw) + SUM_W'(h0) + SUM_W'(h1);
        three_raw = {1'b0, raw, 1'b0} + SUM_W'(raw);
        gap       = (three_raw > sum) ? three_raw - sum : sum - three_raw;
        thr3      = {1'b0, thr_reg, 1'b0} + SUM_W'(thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.filt) begin
            sum_reg     <= sum;
            outlier_reg <= gap > thr3;
            prev_reg    <= h0;
        end
    end

    // Mean by reciprocal of three; pick previous sample on outlier
    assign mean_prod = MEAN_PROD_W'(sum_reg) * MEAN_PROD_W'(MEAN_RECIP);
    assign mean      = mean_prod[MEAN_SHIFT +: RANGE_W];

    always_ff @(posedge aclk) begin
        if (cmd.mean) begin
            if (!in_range) begin
                f_reg <= '0;
            end else if (outlier_reg) begin
                f_reg <= prev_reg;
            end else begin
                f_reg <= mean;
            end
        end
    end

    assign capped  = (f_reg > CAP_MM) ? CAP_MM : f_reg;
    assign bearing = $signed(BEARING_W'(idx_reg) * BEARING_STEP - BEARING_OFFSET);

    // Saturating sums of the weighted bearing and the weight
    always_comb begin
        aws_sum = $signed({aws_reg[AWS_W-1], aws_reg}) + (AWS_W+1)'(prod_reg);
        ws_sum  = {1'b0, ws_reg} + (WS_W+1)'(div_quotient[WEIGHT_W-1:0]);
        aws_mag = aws_reg[AWS_W-1] ? DIVIDEND_W'(-aws_reg) : DIVIDEND_W'(aws_reg);
    end

    // Clamp the truncated quotient to the bearing range
    always_comb begin
        if (aws_reg[AWS_W-1]) begin
            angle = (div_quotient > ANGLE_NEG_MAG) ? ANGLE_LOW
                  : $signed(ANGLE_W'(0) - div_quotient[ANGLE_W-1:0]);
        end else begin
            angle = (div_quotient > ANGLE_POS_MAG) ? ANGLE_HIGH
                  : $signed(div_quotient[ANGLE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= bearing * $signed({1'b0, div_quotient[WEIGHT_W-1:0]});
        end
    end

    // Scan state: minima, sums and held bearing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmin_reg <= CAP_MM;
            smin_reg <= CAP_MM;
            aws_reg  <= '0;
            ws_reg   <= '0;
            held_reg <= '0;
        end else begin
            if (cmd.acc && in_range) begin
                if (front_mask_reg[idx_reg] && capped < fmin_reg) begin
                    fmin_reg <= capped;
                end
                if (side_mask_reg[idx_reg] && capped < smin_reg) begin
                    smin_reg <= capped;
                end
            end
            if (cmd.sum) begin
                if (aws_sum > AWS_POS_SAT) begin
                    aws_reg <= AWS_POS_SAT[AWS_W-1:0];
                end else if (aws_sum < AWS_NEG_SAT) begin
                    aws_reg <= AWS_NEG_SAT[AWS_W-1:0];
                end else begin
                    aws_reg <= aws_sum[AWS_W-1:0];
                end
                ws_reg <= ws_sum[WS_W] ? WS_SAT : ws_sum[WS_W-1:0];
            end
            if (cmd.angle_take) begin
                held_reg <= angle;
            end else if (cmd.angle_zero) begin
                held_reg <= '0;
            end
            // Close the scan after its summary goes out
            if (cmd.emit && last_reg) begin
                fmin_reg <= CAP_MM;
                smin_reg <= CAP_MM;
                aws_reg  <= '0;
                ws_reg   <= '0;
            end
        end
    end

    // Shared divider: weight 2^24/(f+1), or scan bearing |aws|/ws
    assign div_start    = cmd.wdiv_start || cmd.adiv_start;
    assign div_dividend = cmd.adiv_start ? aws_mag : WEIGHT_DIVIDEND;
    assign div_divisor  = cmd.adiv_start ? ws_reg : DIVISOR_W'(f_reg) + DIVISOR_W'(1);
    assign div_steps    = cmd.adiv_start ? ANGLE_STEPS : WEIGHT_STEPS;

    sonrc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign obstacle = fmin_reg < safe_reg;
    assign unsafe   = !(fmin_reg > crit_reg);

    // Output register: load on emit, drop valid when the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_last_reg <= last_reg;
            if (last_reg) begin
                out_data_reg <= {2'b00, unsafe, held_reg, obstacle,
                                 smin_reg, fmin_reg, f_reg};
            end else begin
                out_data_reg <= {{(M_TDATA_W-RANGE_W){1'b0}}, f_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        stat.near       = in_range && (f_reg < safe_reg);
        stat.last       = last_reg;
        stat.obstacle   = obstacle;
        stat.ws_nonzero = ws_reg != '0;
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ----- sv/sonar_range_conditioner.sv -----
// Sonar range conditioner: takes one reading per input beat and returns one result beat.
// Each sensor's range is the mean of its last three raw samples, or the previous raw
// sample when the newest one strays from the mean by more than the outlier threshold.
// Over a scan the block tracks capped front and side minima and a bearing weighted by
// 2^24/(range+1) over sensors inside the safe distance; the beat with s_tlast returns
// the scan summary with m_tlast set and then starts a new scan. One beat is in work at
// a time: each reading passes accept, read, filter, mean, accumulate and emit; a reading
// inside the safe distance adds a 25-step weight division, a multiply and a sum, a
// scan-closing beat adds a scan step, and one that sees an obstacle with weight gathered
// adds a 40-step bearing division. Both divisions share one shift-subtract divider, and a
// full output register holds the next result back until its beat is taken. A finished
// beat waits in the output register while the next reading is taken. Write configuration
// only while no reading is in work.
`timescale 1ns / 1ps
`default_nettype none

module sonar_range_conditioner
    import sonrc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [3:0] sensor_index, [16:4] range_mm, [23:17] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] reading_present
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [12:0] filtered_mm, [25:13] min_front_mm, [38:26] min_side_mm,
    // [39] obstacle_seen, [52:40] obstacle_bearing, [53] unsafe_to_move, [55:54] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    // summary_valid
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    sonrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sonrc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .sensor_index    (s_tdata[INDEX_W-1:0]),
        .range_mm        (s_tdata[INDEX_W +: RANGE_W]),
        .reading_present (s_tuser),
        .end_of_scan     (s_tlast),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

`ifndef SYNTHESIS
    // One reading in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a reading is in work");

    // Never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a pending beat");

    // An emitted result shows up on the output next cycle
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

    // Summary fields stay zero outside scan-closing beats
    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[M_TDATA_W-1:RANGE_W] == '0))
        else $error("summary fields set on a non-closing beat");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sonrc_pkg::*;

    localparam int  HALF_PERIOD  = 2;
    localparam int  PHASE_ITEMS  = 225;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  FLOOD_LEN    = 40;
    localparam int  PRINT_LIMIT  = 40;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED = CFG_SIDE_MASK + 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_UNUSED  = '1;
    localparam longint BEARING_ACC_LIMIT = 64'sd549755813887;
    localparam longint WEIGHT_ACC_LIMIT  = (64'sd1 << 30) - 1;

    // One result beat, split into its fields
    typedef struct packed {
        logic [RANGE_W-1:0]        filt;
        logic                      summary;
        logic [RANGE_W-1:0]        fmin;
        logic [RANGE_W-1:0]        smin;
        logic                      obst;
        logic signed [ANGLE_W-1:0] angle;
        logic                      unsafe;
    } sonar_result_t;

    // One line of the directed table: a register write or a reading
    typedef struct {
        bit                    is_reg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic [INDEX_W-1:0]    idx;
        logic [RANGE_W-1:0]    mm;
        bit                    present;
        bit                    last;
        bit                    typed;
        logic [RANGE_W-1:0]    typed_filt;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Random idling is switched off on both sides while calm is set
    logic calm     = 1'b0;
    logic stall_rx = 1'b0;

    // Predictor copy of the registers and the filter state
    logic [RANGE_W-1:0] safe_mm, crit_mm, gap_mm;
    logic [MASK_W-1:0]  front_mask, side_mask;
    logic [RANGE_W-1:0] hist [SENSOR_COUNT][3];
    int                 front_min, side_min;
    longint             bearing_acc, weight_acc;
    logic signed [ANGLE_W-1:0] held_bearing;

    sonar_result_t pending_results [$];
    stim_row_t     directed [$];
    int            scene_base [SENSOR_COUNT];

    int mismatches   = 0;
    int items_sent   = 0;
    int beats_seen   = 0;
    int scans_closed = 0;
    int obstacle_cnt = 0;
    int reg_writes   = 0;

    sonar_range_conditioner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Print one mismatch line (up to a limit) and count it
    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s after %0d beats: got %0d, want %0d",
                     $time, what, beats_seen, got, want);
        mismatches++;
    endtask

    function automatic void reset_predictor();
        safe_mm    = SAFE_DIST_RST;
        crit_mm    = CRIT_DIST_RST;
        gap_mm     = OUTLIER_RST;
        front_mask = FRONT_MASK_RST;
        side_mask  = SIDE_MASK_RST;
        foreach (hist[i, j]) hist[i][j] = CAP_MM;
        front_min    = int'(CAP_MM);
        side_min     = int'(CAP_MM);
        bearing_acc  = 0;
        weight_acc   = 0;
        held_bearing = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_SAFE_DIST:  safe_mm    = data[RANGE_W-1:0];
            CFG_CRIT_DIST:  crit_mm    = data[RANGE_W-1:0];
            CFG_OUTLIER:    gap_mm     = data[RANGE_W-1:0];
            CFG_FRONT_MASK: front_mask = data;
            CFG_SIDE_MASK:  side_mask  = data;
            default: ;
        endcase
    endfunction

    // Filter one reading, fold it into the scan, and close the scan on the last beat
    function automatic sonar_result_t predict_reading(input logic [INDEX_W-1:0] idx,
                                                      input logic [RANGE_W-1:0] mm,
                                                      input bit present, input bit last);
        sonar_result_t r;
        int     raw, sum3, gap, f, capped;
        longint w, acc, q;
        r = '0;
        raw = present ? int'(mm) : int'(hist[idx][0]);
        hist[idx][2] = hist[idx][1];
        hist[idx][1] = hist[idx][0];
        hist[idx][0] = raw[RANGE_W-1:0];
        sum3 = int'(hist[idx][0]) + int'(hist[idx][1]) + int'(hist[idx][2]);
        gap  = 3 * raw - sum3;
        if (gap < 0) gap = -gap;
        f = (gap > 3 * int'(gap_mm)) ? int'(hist[idx][1]) : sum3 / 3;

        capped = (f > int'(CAP_MM)) ? int'(CAP_MM) : f;
        if (front_mask[idx] && capped < front_min) front_min = capped;
        if (side_mask[idx] && capped < side_min) side_min = capped;
        if (f < int'(safe_mm)) begin
            w   = (longint'(1) << 24) / (f + 1);
            acc = bearing_acc + (longint'(idx) * 360 - 2880) * w;
            if (acc > BEARING_ACC_LIMIT) acc = BEARING_ACC_LIMIT;
            if (acc < -BEARING_ACC_LIMIT) acc = -BEARING_ACC_LIMIT;
            bearing_acc = acc;
            weight_acc  = weight_acc + w;
            if (weight_acc > WEIGHT_ACC_LIMIT) weight_acc = WEIGHT_ACC_LIMIT;
        end
        r.filt = f[RANGE_W-1:0];

        if (last) begin
            r.summary = 1'b1;
            r.obst    = front_min < int'(safe_mm);
            r.unsafe  = front_min <= int'(crit_mm);
            // Hold the previous bearing unless the front sees something
            if (r.obst) begin
                q = (weight_acc > 0) ? bearing_acc / weight_acc : 0;
                if (q < longint'(ANGLE_LOW)) q = longint'(ANGLE_LOW);
                if (q > longint'(ANGLE_HIGH)) q = longint'(ANGLE_HIGH);
                held_bearing = q[ANGLE_W-1:0];
            end
            r.fmin  = front_min[RANGE_W-1:0];
            r.smin  = side_min[RANGE_W-1:0];
            r.angle = held_bearing;
            front_min   = int'(CAP_MM);
            side_min    = int'(CAP_MM);
            bearing_acc = 0;
            weight_acc  = 0;
        end
        return r;
    endfunction

    // Write one register; cfg_valid is dropped by the next reading
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(addr, data);
        reg_writes++;
    endtask

    // Offer one reading after a random gap and hold it until it is taken
    task automatic offer_reading(input logic [INDEX_W-1:0] idx, input logic [RANGE_W-1:0] mm,
                                 input bit present, input bit last,
                                 input bit typed, input logic [RANGE_W-1:0] typed_filt);
        sonar_result_t r;
        int gap_cycles;
        cfg_valid <= 1'b0;
        gap_cycles = 0;
        while (!calm && $urandom_range(99) < 37) gap_cycles++;
        if (gap_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        r = predict_reading(idx, mm, present, last);
        if (typed) r.filt = typed_filt;
        pending_results = {pending_results, r};
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-INDEX_W-RANGE_W){1'b0}}, mm, idx};
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait until every expected beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic stim_row_t reading_row(input logic [INDEX_W-1:0] idx,
                                              input logic [RANGE_W-1:0] mm,
                                              input bit present, input bit last,
                                              input bit typed,
                                              input logic [RANGE_W-1:0] filt);
        stim_row_t row;
        row = '{is_reg: 1'b0, addr: '0, wdata: '0, idx: idx, mm: mm, present: present,
                last: last, typed: typed, typed_filt: filt};
        return row;
    endfunction

    function automatic stim_row_t register_row(input logic [CFG_ADDR_W-1:0] addr,
                                               input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{is_reg: 1'b1, addr: addr, wdata: data, idx: '0, mm: '0, present: 1'b0,
                last: 1'b0, typed: 1'b0, typed_filt: '0};
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input stim_row_t row);
        directed = {directed, row};
    endfunction

    // Drifting scene per sensor, with the odd spike and rail value
    function automatic logic [RANGE_W-1:0] next_range(input int i);
        int roll, v;
        roll = $urandom_range(99);
        scene_base[i] = scene_base[i] + $urandom_range(200) - 100;
        if (scene_base[i] < 0) scene_base[i] = 0;
        if (scene_base[i] > 8191) scene_base[i] = 8191;
        if (roll < 8) return RANGE_W'($urandom_range(8191));
        if (roll < 12) return '0;
        if (roll < 16) return '1;
        v = scene_base[i] + $urandom_range(80) - 40;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
        return v[RANGE_W-1:0];
    endfunction

    // Well-formed scan: ascending subset of the sensors, last one marked
    task automatic run_scan();
        bit pick [SENSOR_COUNT];
        int last_i;
        bit full;
        full   = ($urandom_range(2) == 0);
        last_i = -1;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            pick[i] = full || ($urandom_range(99) < 55);
            if (pick[i]) last_i = i;
        end
        if (last_i < 0) begin
            last_i = $urandom_range(SENSOR_COUNT - 1);
            pick[last_i] = 1'b1;
        end
        for (int i = 0; i <= last_i; i++)
            if (pick[i])
                offer_reading(INDEX_W'(i), next_range(i), $urandom_range(99) >= 10,
                              i == last_i, 1'b0, '0);
    endtask

    // Broken sequence: any order, repeats, marks at random
    task automatic run_noise();
        int n;
        n = $urandom_range(8, 1);
        repeat (n)
            offer_reading(INDEX_W'($urandom_range(15)), RANGE_W'($urandom_range(8191)),
                          1'($urandom_range(1)), $urandom_range(99) < 20, 1'b0, '0);
    endtask

    // Long scan of near readings at both ends of the array to drive the sums into saturation
    task automatic run_flood();
        repeat (FLOOD_LEN) offer_reading(INDEX_W'(15), '0, 1'b1, 1'b0, 1'b0, '0);
        repeat (FLOOD_LEN) offer_reading(INDEX_W'(0), '0, 1'b1, 1'b0, 1'b0, '0);
        offer_reading(INDEX_W'(15), '0, 1'b1, 1'b1, 1'b0, '0);
    endtask

    task automatic load_phase_settings(input int phase);
        logic [CFG_DATA_W-1:0] sd, cd, og, fm, sm, junk;
        junk = CFG_DATA_W'($urandom_range(7)) << RANGE_W;
        case (phase)
            0: begin
                sd = junk; cd = '0; og = '0; fm = '0; sm = '0;
            end
            1: begin
                sd = '1; cd = '1; og = '1; fm = '1; sm = '1;
            end
            2: begin
                sd = 16'd1500 | junk; cd = 16'd600; og = 16'd300;
                fm = CFG_DATA_W'($urandom); sm = CFG_DATA_W'($urandom);
            end
            3: begin
                sd = CFG_DATA_W'($urandom); cd = CFG_DATA_W'($urandom);
                og = CFG_DATA_W'($urandom); fm = CFG_DATA_W'($urandom);
                sm = CFG_DATA_W'($urandom);
            end
            default: begin
                sd = 16'd8191; cd = 16'd5000; og = CFG_DATA_W'($urandom_range(60));
                fm = CFG_DATA_W'($urandom); sm = CFG_DATA_W'($urandom);
            end
        endcase
        cfg_write(CFG_SAFE_DIST, sd);
        cfg_write(CFG_CRIT_DIST, cd);
        cfg_write(CFG_OUTLIER, og);
        cfg_write(CFG_FRONT_MASK, fm);
        cfg_write(CFG_SIDE_MASK, sm);
        cfg_write(CFG_FIRST_UNUSED + CFG_ADDR_W'($urandom_range(2)), CFG_DATA_W'($urandom));
    endtask

    // Compare each taken result beat with the oldest expectation
    task automatic check_result_beat();
        sonar_result_t got, want;
        got.filt    = m_tdata[12:0];
        got.fmin    = m_tdata[25:13];
        got.smin    = m_tdata[38:26];
        got.obst    = m_tdata[39];
        got.angle   = m_tdata[52:40];
        got.unsafe  = m_tdata[53];
        got.summary = m_tlast;
        beats_seen++;
        if (pending_results.size() == 0) begin
            note_mismatch("beat with nothing expected", m_tdata, '0);
        end else begin
            want = pending_results.pop_front();
            if (got.filt !== want.filt) note_mismatch("filtered_mm", got.filt, want.filt);
            if (got.summary !== want.summary)
                note_mismatch("summary_valid", got.summary, want.summary);
            if (got.fmin !== want.fmin) note_mismatch("min_front_mm", got.fmin, want.fmin);
            if (got.smin !== want.smin) note_mismatch("min_side_mm", got.smin, want.smin);
            if (got.obst !== want.obst) note_mismatch("obstacle_seen", got.obst, want.obst);
            if (got.angle !== want.angle)
                note_mismatch("obstacle_bearing", got.angle, want.angle);
            if (got.unsafe !== want.unsafe) note_mismatch("unsafe_to_move", got.unsafe, want.unsafe);
            if (want.summary) scans_closed++;
            if (want.summary && want.obst) obstacle_cnt++;
        end
    endtask

    // Result side: check taken beats, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result_beat();
        m_tready <= !stall_rx && (calm || $urandom_range(99) >= 37);
    end

    // Long receiver hold-off while readings keep coming, to back the block up
    initial begin
        wait (items_sent >= 150);
        @(posedge aclk);
        stall_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        stall_rx <= 1'b0;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        bit prev_reg;
        int roll, phase_start;

        reset_predictor();
        foreach (scene_base[i]) scene_base[i] = $urandom_range(2500);

        // Fresh history is all 5000, so the first readings are easy to read off
        add_row(register_row(CFG_FIRST_UNUSED, 16'h0000));
        add_row(reading_row(4'd0, 13'd0, 1'b0, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd1, 13'd5000, 1'b1, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd2, 13'd0, 1'b1, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd3, 13'd8191, 1'b1, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd4, 13'd4000, 1'b1, 1'b0, 1'b1, 13'd4666));
        add_row(reading_row(4'd15, 13'd0, 1'b1, 1'b1, 1'b1, 13'd5000));
        // Front obstacle at sensor 2, unsafe as well
        add_row(reading_row(4'd2, 13'd0, 1'b1, 1'b0, 1'b0, '0));
        add_row(reading_row(4'd3, 13'd8191, 1'b1, 1'b0, 1'b0, '0));
        add_row(reading_row(4'd14, 13'd0, 1'b1, 1'b1, 1'b1, 13'd5000));
        // Clear front: the bearing is held
        add_row(reading_row(4'd1, 13'd5000, 1'b1, 1'b1, 1'b1, 13'd5000));
        // Obstacle with no weight gathered: bearing drops to zero
        add_row(register_row(CFG_LAST_UNUSED, 16'hFFFF));
        add_row(register_row(CFG_SAFE_DIST, 16'd5001));
        add_row(reading_row(4'd3, 13'd8191, 1'b1, 1'b1, 1'b0, '0));
        // Back to a normal safe distance, upper data bits ignored
        add_row(register_row(CFG_SAFE_DIST, 16'hE320));
        add_row(reading_row(4'd0, 13'd8191, 1'b0, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd5, 13'd300, 1'b1, 1'b0, 1'b0, '0));
        add_row(reading_row(4'd7, 13'd0, 1'b0, 1'b0, 1'b1, 13'd5000));
        add_row(reading_row(4'd8, 13'd5500, 1'b1, 1'b0, 1'b0, '0));
        add_row(reading_row(4'd12, 13'd100, 1'b1, 1'b0, 1'b0, '0));
        add_row(reading_row(4'd13, 13'd4095, 1'b1, 1'b1, 1'b0, '0));
        // Lone scan mark with nothing else in the scan
        add_row(reading_row(4'd6, 13'd2730, 1'b0, 1'b1, 1'b0, '0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; drain before each run of register writes
        prev_reg = 1'b0;
        foreach (directed[n]) begin
            if (directed[n].is_reg) begin
                if (!prev_reg) wait_drained();
                cfg_write(directed[n].addr, directed[n].wdata);
            end else begin
                offer_reading(directed[n].idx, directed[n].mm, directed[n].present,
                              directed[n].last, directed[n].typed, directed[n].typed_filt);
            end
            prev_reg = directed[n].is_reg;
        end

        // Random phases, one register setting each
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            load_phase_settings(phase);
            if (phase == 2) calm <= 1'b1;
            if (phase == 1) run_flood();
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 85)
                    run_scan();
                else if (roll < 95)
                    run_noise();
                else
                    offer_reading(INDEX_W'($urandom_range(15)), next_range(0),
                                  1'($urandom_range(1)), 1'b1, 1'b0, '0);
            end
            if (phase == 2) calm <= 1'b0;
        end

        wait_drained();
        repeat (100) @(posedge aclk);

        $display("Sent %0d readings over %0d closed scans (%0d saw an obstacle); %0d beats checked",
                 items_sent, scans_closed, obstacle_cnt, beats_seen);
        $display("Applied %0d register writes across reset, zero, full-scale and random settings",
                 reg_writes);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sonrc_pkg.sv
sv/sonrc_divider.sv
sv/sonrc_ctrl.sv
sv/sonrc_datapath.sv
sv/sonar_range_conditioner.sv
bench/tb.sv
